### design/utf8ld_pkg.sv
// Shared types, constants and byte-class helpers for the lenient UTF-8 decoder.
// No dependencies; used by utf8ld_decode, utf8ld_emit and utf8_lenient_decoder.
package utf8ld_pkg;

	localparam int CP_W    = 21;
	localparam int USED_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int MAX_RES = 4;

	localparam logic [7:0] ASCII_LIM = 8'h80;
	localparam logic [7:0] LEAD_MIN  = 8'hC2;
	localparam logic [7:0] LEAD_MAX  = 8'hF4;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] PAY_MASK  = 8'h3F;
	localparam logic [7:0] LEAD2_PAY = 8'h1F;
	localparam logic [7:0] LEAD3_PAY = 8'h0F;
	localparam logic [7:0] LEAD4_PAY = 8'h07;

	// one decoded character
	typedef struct packed {
		logic [USED_W-1:0] used;
		logic [CP_W-1:0]   cp;
	} result_t;

	// all characters completed by one input byte
	typedef struct packed {
		logic [2:0]                 count;
		logic                       eos;
		result_t [MAX_RES-1:0]      res;
	} group_t;

	// sequence length implied by a byte taken as a lead
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] n;
		if (b < ASCII_LIM || b < LEAD_MIN || b > LEAD_MAX) begin
			n = 3'd1;
		end else if (b < LEAD3_MIN) begin
			n = 3'd2;
		end else if (b < LEAD4_MIN) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_TAG;
	endfunction

	// byte passed out unchanged as a one-byte character
	function automatic result_t raw_char(input logic [7:0] b);
		result_t r;
		r.cp   = {{(CP_W-BYTE_W){1'b0}}, b};
		r.used = 3'd1;
		return r;
	endfunction

endpackage

### design/utf8ld_decode.sv
// Decode stage: held partial-sequence state and the per-byte character logic.
// Depends on utf8ld_pkg for types, byte classes and masks.
module utf8ld_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             in_byte,
	input  logic                   end_of_string,
	output utf8ld_pkg::group_t     group
);

	logic [7:0] held_q [3];
	logic [1:0] held_count_q;

	logic [1:0] held_count_d;
	logic       wr_en;
	logic [1:0] wr_idx;

	// build the result group and the next held state
	always_comb begin
		logic [2:0] need;
		logic [2:0] need_b;
		logic       fresh_raw;
		logic [utf8ld_pkg::CP_W-1:0] cp;
		utf8ld_pkg::result_t dec;
		group.eos   = end_of_string;
		group.count = 3'd0;
		for (int i = 0; i < utf8ld_pkg::MAX_RES; i++) begin
			if (2'(i) < held_count_q) begin
				group.res[i] = utf8ld_pkg::raw_char(held_q[i]);
			end else begin
				group.res[i] = utf8ld_pkg::raw_char(in_byte);
			end
		end
		need      = utf8ld_pkg::seq_len(held_q[0]);
		need_b    = utf8ld_pkg::seq_len(in_byte);
		fresh_raw = (need_b == 3'd1) || end_of_string;
		held_count_d = held_count_q;
		wr_en  = 1'b0;
		wr_idx = 2'd0;

		// assemble the code point of a sequence this byte completes
		unique case (need)
			3'd2: cp = {10'd0, held_q[0][4:0] & utf8ld_pkg::LEAD2_PAY[4:0],
				in_byte[5:0] & utf8ld_pkg::PAY_MASK[5:0]};
			3'd3: cp = {5'd0, held_q[0][3:0] & utf8ld_pkg::LEAD3_PAY[3:0],
				held_q[1][5:0] & utf8ld_pkg::PAY_MASK[5:0],
				in_byte[5:0] & utf8ld_pkg::PAY_MASK[5:0]};
			default: cp = {held_q[0][2:0] & utf8ld_pkg::LEAD4_PAY[2:0],
				held_q[1][5:0] & utf8ld_pkg::PAY_MASK[5:0],
				held_q[2][5:0] & utf8ld_pkg::PAY_MASK[5:0],
				in_byte[5:0] & utf8ld_pkg::PAY_MASK[5:0]};
		endcase
		dec.cp   = cp;
		dec.used = need;

		priority if (held_count_q == 2'd0) begin
			// fresh byte: pass out, or start holding a lead
			if (fresh_raw) begin
				group.count  = 3'd1;
			end else begin
				wr_en        = 1'b1;
				held_count_d = 2'd1;
			end
		end else if (utf8ld_pkg::is_cont(in_byte)) begin
			priority if ({1'b0, held_count_q} + 3'd1 == need) begin
				group.res[0] = dec;
				group.count  = 3'd1;
				held_count_d = 2'd0;
			end else if (end_of_string) begin
				// cut short: lead and continuations all drop to raw
				group.count  = {1'b0, held_count_q} + 3'd1;
				held_count_d = 2'd0;
			end else begin
				wr_en        = 1'b1;
				wr_idx       = held_count_q;
				held_count_d = held_count_q + 2'd1;
			end
		end else begin
			// broken sequence: drain held bytes raw, then rescan the new byte
			if (fresh_raw) begin
				group.count  = {1'b0, held_count_q} + 3'd1;
				held_count_d = 2'd0;
			end else begin
				group.count  = {1'b0, held_count_q};
				wr_en        = 1'b1;
				held_count_d = 2'd1;
			end
		end
	end

	// advance held count on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= 2'd0;
		end else if (accept) begin
			held_count_q <= held_count_d;
		end
	end

	// store a held byte; payload only, no reset
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			held_q[wr_idx] <= in_byte;
		end
	end

endmodule

### design/utf8ld_emit.sv
// Result register: stores one result group and hands its characters out one per word.
// Depends on utf8ld_pkg for the group and result types.
module utf8ld_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  utf8ld_pkg::group_t   group,
	output logic                 free,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,
	output logic                 m_tlast
);

	utf8ld_pkg::group_t group_q;
	logic               valid_q;
	logic [1:0]         idx_q;
	logic               final_word;
	utf8ld_pkg::result_t cur;

	assign cur        = group_q.res[idx_q];
	assign final_word = ({1'b0, idx_q} == group_q.count - 3'd1);
	assign m_tvalid   = valid_q;
	assign m_tdata    = {cur.used, cur.cp};
	assign m_tlast    = group_q.eos && final_word;
	assign free       = !valid_q || (m_tready && final_word);

	// load a new group or advance through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (free) begin
			valid_q <= load && (group.count != 3'd0);
			idx_q   <= 2'd0;
		end else if (m_tready) begin
			idx_q   <= idx_q + 2'd1;
		end
	end

	// hold group payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			group_q <= group;
		end
	end

endmodule

### design/utf8_lenient_decoder.sv
// Top level of the lenient UTF-8 decoder: stream ports, decode stage and result register.
// Depends on utf8ld_pkg, utf8ld_decode and utf8ld_emit.
//
// Takes one byte per word on the slave side, with tlast marking the final byte of a
// string, and gives one decoded character per word on the master side. Leads 0xC2..0xF4
// start 2, 3 or 4 byte sequences; bad leads, broken or truncated sequences and stray
// continuations come out as raw bytes with bytes_used of 1, and tlast is set on the final
// character of each string. Plain text streams at one byte per clock while m_tready stays
// high; a byte that flushes k characters keeps the input stalled while the result register
// hands them out one per word. The decode logic sits between the held-byte state and the
// result register, and the input is taken whenever the result register is empty or hands
// out its last character.
module utf8_lenient_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] bytes_used
	output logic        m_tlast    // last_char
);

	utf8ld_pkg::group_t group;
	logic               free;
	logic               accept;

	assign s_tready = free;
	assign accept   = s_tvalid && free;

	utf8ld_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (s_tdata),
		.end_of_string (s_tlast),
		.group         (group)
	);

	utf8ld_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.group    (group),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### sim/utf8_lenient_decoder_test.sv
// Self-checking testbench for utf8_lenient_decoder: byte stream in, decoded characters out.
// Depends on utf8ld_pkg and the decoder RTL; the expected characters come from a decoder
// model kept in this file.
`timescale 1ns / 1ps

module utf8_lenient_decoder_test;

	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [utf8ld_pkg::CP_W-1:0]   cp;
		logic [utf8ld_pkg::USED_W-1:0] used;
		logic                          last;
	} decoded_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
	logic        s_tlast = 1'b0;    // end_of_string
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;           // [20:0] code_point, [23:21] bytes_used
	logic        m_tlast;           // last_char

	// model state: bytes of an unfinished sequence
	logic [7:0]      held [3];
	int              held_n = 0;
	decoded_char_t   chars_due [$];
	int              errors = 0;
	int              cycles = 0;
	int              gap_pct = 0;
	int              stall_pct = 0;
	int              hold_cycles = 0;

	// short strings: extremes, bad leads, stray continuation, truncation, worst-case flush
	logic [8:0] sample_text [0:23] = '{
		9'h000, 9'h17F,
		9'h0C2, 9'h080, 9'h0DF, 9'h0BF,
		9'h0EF, 9'h0BF, 9'h1BF,
		9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
		9'h0C0, 9'h0C1, 9'h0F5, 9'h0FF, 9'h180,
		9'h0E2, 9'h182,
		9'h0F0, 9'h080, 9'h080, 9'h141
	};

	utf8_lenient_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// abort a run that hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("utf8_lenient_decoder_test: FAIL");
			$finish;
		end
	end

	// random receiver stalls; a hold-off request overrides them for its length
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// decode one accepted byte and queue the characters it completes
	task automatic decode_byte(input logic [7:0] in_byte, input logic eos);
		logic [7:0]      seq [4];
		decoded_char_t   found [4];
		int              n, pos, got, need, k;
		logic            bad, waiting;
		logic [utf8ld_pkg::CP_W-1:0] cp;
		n = held_n;
		for (k = 0; k < n; k++)
			seq[k] = held[k];
		seq[n] = in_byte;
		n++;
		pos = 0;
		got = 0;
		waiting = 1'b0;
		while (pos < n && got < utf8ld_pkg::MAX_RES && !waiting) begin
			if (seq[pos] < utf8ld_pkg::LEAD_MIN || seq[pos] > utf8ld_pkg::LEAD_MAX)
				need = 1;
			else if (seq[pos] < utf8ld_pkg::LEAD3_MIN)
				need = 2;
			else if (seq[pos] < utf8ld_pkg::LEAD4_MIN)
				need = 3;
			else
				need = 4;
			bad = 1'b0;
			for (k = 1; k < need && pos + k < n; k++)
				if ((seq[pos + k] & utf8ld_pkg::CONT_MASK) != utf8ld_pkg::CONT_TAG)
					bad = 1'b1;
			if (need == 1 || bad || (n - pos < need && eos)) begin
				// fall back: the lead goes out alone, rescan what follows
				found[got].cp = utf8ld_pkg::CP_W'(seq[pos]);
				found[got].used = 3'd1;
				found[got].last = 1'b0;
				got++;
				pos++;
			end else if (n - pos < need) begin
				waiting = 1'b1;
			end else begin
				case (need)
					2: cp = utf8ld_pkg::CP_W'({seq[pos][4:0], seq[pos + 1][5:0]});
					3: cp = utf8ld_pkg::CP_W'({seq[pos][3:0], seq[pos + 1][5:0],
						seq[pos + 2][5:0]});
					default: cp = {seq[pos][2:0], seq[pos + 1][5:0], seq[pos + 2][5:0],
						seq[pos + 3][5:0]};
				endcase
				found[got].cp = cp;
				found[got].used = utf8ld_pkg::USED_W'(need);
				found[got].last = 1'b0;
				got++;
				pos += need;
			end
		end
		// keep the unfinished tail
		held_n = 0;
		while (pos < n && held_n < 3) begin
			held[held_n] = seq[pos];
			held_n++;
			pos++;
		end
		if (eos && got > 0)
			found[got - 1].last = 1'b1;
		for (k = 0; k < got; k++)
			chars_due.push_back(found[k]);
	endtask

	// compare each delivered word with the oldest expected character, then predict
	always @(posedge clk) begin : check_chars
		decoded_char_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (chars_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word cp=%h used=%0d last=%b", $time,
						m_tdata[utf8ld_pkg::CP_W-1:0],
						m_tdata[utf8ld_pkg::CP_W +: utf8ld_pkg::USED_W], m_tlast);
				end else begin
					want = chars_due.pop_front();
					if (m_tdata[utf8ld_pkg::CP_W-1:0] !== want.cp) begin
						errors++;
						$display("%0t: code_point expected %h actual %h", $time,
							want.cp, m_tdata[utf8ld_pkg::CP_W-1:0]);
					end
					if (m_tdata[utf8ld_pkg::CP_W +: utf8ld_pkg::USED_W] !== want.used) begin
						errors++;
						$display("%0t: bytes_used expected %0d actual %0d", $time,
							want.used, m_tdata[utf8ld_pkg::CP_W +: utf8ld_pkg::USED_W]);
					end
					if (m_tlast !== want.last) begin
						errors++;
						$display("%0t: last_char expected %b actual %b", $time,
							want.last, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
		end
	end

	// offer one byte after a random gap and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(99, 0) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eos;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// change idling between phases, away from the rising edge
	task automatic set_idling(input int gap, input int stall, input int hold);
		@(negedge clk);
		gap_pct = gap;
		stall_pct = stall;
		hold_cycles = hold;
		@(posedge clk);
	endtask

	// drop valid, wait for every expected character, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (chars_due.size() != 0)
			@(negedge clk);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed characters; some bad leads, truncated and broken sequences
	task automatic send_text(input int n_bytes);
		logic [7:0] seq [4];
		int         len, cut, k, sent;
		logic       eos;
		sent = 0;
		while (sent < n_bytes) begin
			len = $urandom_range(4, 1);
			case (len)
				1: seq[0] = 8'($urandom_range(8'h7F, 8'h00));
				2: seq[0] = 8'($urandom_range(utf8ld_pkg::LEAD3_MIN - 1, utf8ld_pkg::LEAD_MIN));
				3: seq[0] = 8'($urandom_range(utf8ld_pkg::LEAD4_MIN - 1,
					utf8ld_pkg::LEAD3_MIN));
				default: seq[0] = 8'($urandom_range(utf8ld_pkg::LEAD_MAX,
					utf8ld_pkg::LEAD4_MIN));
			endcase
			for (k = 1; k < len; k++)
				seq[k] = utf8ld_pkg::CONT_TAG | 8'($urandom_range(63, 0));
			cut = len;
			case ($urandom_range(9, 0))
				0: seq[0] = 8'($urandom_range(255, 0));
				1: if (len > 1) cut = $urandom_range(len - 1, 1);
				2: if (len > 1) seq[$urandom_range(len - 1, 1)] = 8'($urandom_range(255, 0));
				default: ;
			endcase
			eos = ($urandom_range(7, 0) == 0);
			for (k = 0; k < cut; k++) begin
				send_byte(seq[k], eos && k == cut - 1);
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		int k;
		set_idling(0, 0, 0);
		for (k = 0; k < 24; k++)
			send_byte(sample_text[k][7:0], sample_text[k][8]);
		drain();
	endtask

	task automatic test_streaming();
		set_idling(0, 0, 0);
		send_text(28);
		drain();
	endtask

	task automatic test_sender_gaps();
		set_idling(72, 0, 0);
		send_text(28);
		drain();
	endtask

	task automatic test_receiver_stalls();
		set_idling(0, 72, 0);
		send_text(28);
		drain();
	endtask

	task automatic test_both_idle();
		set_idling(21, 21, 0);
		send_text(28);
		drain();
	endtask

	// receiver holds off while bytes keep coming, so the input backs up
	task automatic test_backpressure();
		set_idling(0, 0, HOLD_OFF_CYCLES);
		send_text(20);
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();
		if (errors == 0) begin
			$display("utf8_lenient_decoder_test: PASS");
		end else begin
			$display("utf8_lenient_decoder_test: FAIL");
		end
		$finish;
	end

endmodule
